// ----- design/sic_pkg.sv -----
package sic_pkg;

  // Tolerance register format and its value after reset.
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

endpackage

// ----- design/sic_if.sv -----
// Input beat: two segments given by their endpoints.
interface sic_in_if #(
  parameter int COORD_BITS = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] seg1_start_x;
  logic signed [COORD_BITS-1:0] seg1_start_y;
  logic signed [COORD_BITS-1:0] seg1_end_x;
  logic signed [COORD_BITS-1:0] seg1_end_y;
  logic signed [COORD_BITS-1:0] seg2_start_x;
  logic signed [COORD_BITS-1:0] seg2_start_y;
  logic signed [COORD_BITS-1:0] seg2_end_x;
  logic signed [COORD_BITS-1:0] seg2_end_y;

  modport source (
    output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    output ready
  );
endinterface

// Result beat: hit flag, both parameters and the crossing point.
interface sic_out_if #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
);
  logic valid;
  logic ready;
  logic hit;
  logic signed [FRAC_BITS+2:0]            param_first;
  logic signed [FRAC_BITS+2:0]            param_second;
  logic signed [COORD_BITS+FRAC_BITS+2:0] point_x;
  logic signed [COORD_BITS+FRAC_BITS+2:0] point_y;

  modport source (
    output valid, hit, param_first, param_second, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, hit, param_first, param_second, point_x, point_y,
    output ready
  );
endinterface

// ----- design/sic_div_cell.sv -----
// One restoring-division step for two quotients that share a divisor.
module sic_div_cell #(
  parameter int RW     = 36,
  parameter int QB     = 19,
  parameter int SIDE_W = 70
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [RW-1:0]          d_i,
  input  logic [1:0][RW-1:0]     r_i,
  input  logic [1:0][QB-1:0]     n_i,
  input  logic [1:0][QB-1:0]     q_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [RW-1:0]          d_o,
  output logic [1:0][RW-1:0]     r_o,
  output logic [1:0][QB-1:0]     n_o,
  output logic [1:0][QB-1:0]     q_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic                  vld_r;
  logic [RW-1:0]         d_r;
  logic [1:0][RW-1:0]    r_r, r_nxt;
  logic [1:0][QB-1:0]    n_r, n_nxt;
  logic [1:0][QB-1:0]    q_r, q_nxt;
  logic [SIDE_W-1:0]     side_r;
  logic [1:0][RW-1:0]    r_sh;
  logic [1:0][RW:0]      dif;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      r_sh[k] = {r_i[k][RW-2:0], n_i[k][QB-1]};
      dif[k]  = {1'b0, r_sh[k]} - {1'b0, d_i};
      r_nxt[k] = dif[k][RW] ? r_sh[k] : dif[k][RW-1:0];
      n_nxt[k] = {n_i[k][QB-2:0], 1'b0};
      q_nxt[k] = {q_i[k][QB-2:0], ~dif[k][RW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_i;
      r_r    <= r_nxt;
      n_r    <= n_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign d_o    = d_r;
  assign r_o    = r_r;
  assign n_o    = n_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

// ----- design/segment_intersection_core.sv -----
// Pipeline: 8 + (FRAC_BITS+3) register stages from input beat to result beat.
// Throughput: one pair of segments per cycle; one divider cell per quotient bit.
// The whole pipeline holds while a result beat waits on a low out_ch.ready.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the
// tolerance to 66.
module segment_intersection_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sic_in_if.sink                             in_ch,
  sic_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [sic_pkg::TOL_W-1:0]          cfg_wr_data
);

  localparam int CW     = COORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int SW     = PW + 1;
  localparam int MW     = SW;
  localparam int QB     = F + 3;
  localparam int NW     = MW + F;
  localparam int RW     = MW + 1;
  localparam int SIDE_W = 2 * CW + 2 * DW + 3;
  localparam int CMPW   = ((QB > sic_pkg::TOL_W) ? QB : sic_pkg::TOL_W) + 2;
  localparam int MULW   = QB + DW;
  localparam int POW    = CW + F + 3;
  localparam logic signed [CMPW-1:0] ONE_C = CMPW'(2 ** F);

  logic en;
  logic [sic_pkg::TOL_W-1:0] tol_r;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sic_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // The pipeline advances unless the output register is full and stalled.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: coordinate differences.
  logic v1_r;
  logic signed [CW-1:0] x1_1_r, y1_1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_1_r <= in_ch.seg1_start_x;
      y1_1_r <= in_ch.seg1_start_y;
      dx1_r  <= DW'(in_ch.seg1_end_x) - DW'(in_ch.seg1_start_x);
      dy1_r  <= DW'(in_ch.seg1_end_y) - DW'(in_ch.seg1_start_y);
      dx2_r  <= DW'(in_ch.seg2_end_x) - DW'(in_ch.seg2_start_x);
      dy2_r  <= DW'(in_ch.seg2_end_y) - DW'(in_ch.seg2_start_y);
      ox_r   <= DW'(in_ch.seg1_start_x) - DW'(in_ch.seg2_start_x);
      oy_r   <= DW'(in_ch.seg1_start_y) - DW'(in_ch.seg2_start_y);
    end
  end

  // Stage 2: the six cross-product terms.
  logic v2_r;
  logic signed [CW-1:0] x1_2_r, y1_2_r;
  logic signed [DW-1:0] dx1_2_r, dy1_2_r;
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_2_r  <= x1_1_r;
      y1_2_r  <= y1_1_r;
      dx1_2_r <= dx1_r;
      dy1_2_r <= dy1_r;
      p_r[0]  <= dy2_r * dx1_r;
      p_r[1]  <= dx2_r * dy1_r;
      p_r[2]  <= dx2_r * oy_r;
      p_r[3]  <= dy2_r * ox_r;
      p_r[4]  <= dx1_r * oy_r;
      p_r[5]  <= dy1_r * ox_r;
    end
  end

  // Stage 3: denominator and the two numerators.
  logic v3_r;
  logic signed [CW-1:0] x1_3_r, y1_3_r;
  logic signed [DW-1:0] dx1_3_r, dy1_3_r;
  logic signed [SW-1:0] den_r, na_r, nb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_3_r  <= x1_2_r;
      y1_3_r  <= y1_2_r;
      dx1_3_r <= dx1_2_r;
      dy1_3_r <= dy1_2_r;
      den_r   <= SW'(p_r[0]) - SW'(p_r[1]);
      na_r    <= SW'(p_r[2]) - SW'(p_r[3]);
      nb_r    <= SW'(p_r[4]) - SW'(p_r[5]);
    end
  end

  // Stage 4: magnitudes and quotient signs.
  logic v4_r;
  logic signed [CW-1:0] x1_4_r, y1_4_r;
  logic signed [DW-1:0] dx1_4_r, dy1_4_r;
  logic [MW-1:0] dmag_r, namag_r, nbmag_r;
  logic neg_a_4_r, neg_b_4_r, dzero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_4_r    <= x1_3_r;
      y1_4_r    <= y1_3_r;
      dx1_4_r   <= dx1_3_r;
      dy1_4_r   <= dy1_3_r;
      dmag_r    <= den_r[SW-1] ? MW'(-den_r) : MW'(den_r);
      namag_r   <= na_r[SW-1] ? MW'(-na_r) : MW'(na_r);
      nbmag_r   <= nb_r[SW-1] ? MW'(-nb_r) : MW'(nb_r);
      neg_a_4_r <= na_r[SW-1] ^ den_r[SW-1];
      neg_b_4_r <= nb_r[SW-1] ^ den_r[SW-1];
      dzero_r   <= (den_r == '0);
    end
  end

  // Stage 5: split each scaled numerator into a start remainder and the
  // bits the cells still bring down. A start remainder at or above the
  // divisor means the quotient cannot fit.
  logic [NW-1:0] na_sc, nb_sc;
  logic [RW-1:0] ra_init, rb_init, d_ext;
  logic [SIDE_W-1:0] side_4;

  assign na_sc   = {namag_r, {F{1'b0}}};
  assign nb_sc   = {nbmag_r, {F{1'b0}}};
  assign ra_init = RW'(na_sc[NW-1:QB]);
  assign rb_init = RW'(nb_sc[NW-1:QB]);
  assign d_ext   = RW'(dmag_r);
  assign side_4  = {x1_4_r, y1_4_r, dx1_4_r, dy1_4_r, neg_a_4_r, neg_b_4_r,
                    dzero_r || (ra_init >= d_ext) || (rb_init >= d_ext)};

  logic                 c_vld  [QB+1];
  logic [RW-1:0]        c_d    [QB+1];
  logic [1:0][RW-1:0]   c_r    [QB+1];
  logic [1:0][QB-1:0]   c_n    [QB+1];
  logic [1:0][QB-1:0]   c_q    [QB+1];
  logic [SIDE_W-1:0]    c_side [QB+1];

  logic                 v5_r;
  logic [RW-1:0]        d5_r;
  logic [1:0][RW-1:0]   r5_r;
  logic [1:0][QB-1:0]   n5_r;
  logic [SIDE_W-1:0]    side5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d5_r    <= d_ext;
      r5_r    <= {rb_init, ra_init};
      n5_r    <= {nb_sc[QB-1:0], na_sc[QB-1:0]};
      side5_r <= side_4;
    end
  end

  // Head of the chain: the stage 5 registers and an empty quotient.
  assign c_vld[0]  = v5_r;
  assign c_d[0]    = d5_r;
  assign c_r[0]    = r5_r;
  assign c_n[0]    = n5_r;
  assign c_q[0]    = '0;
  assign c_side[0] = side5_r;

  // Chain of division cells, one quotient bit each.
  for (genvar i = 0; i < QB; i++) begin : g_cell
    sic_div_cell #(
      .RW     (RW),
      .QB     (QB),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (c_vld[i]),
      .d_i    (c_d[i]),
      .r_i    (c_r[i]),
      .n_i    (c_n[i]),
      .q_i    (c_q[i]),
      .side_i (c_side[i]),
      .vld_o  (c_vld[i+1]),
      .d_o    (c_d[i+1]),
      .r_o    (c_r[i+1]),
      .n_o    (c_n[i+1]),
      .q_o    (c_q[i+1]),
      .side_o (c_side[i+1])
    );
  end

  // Unpack the sideband at the end of the chain.
  logic signed [CW-1:0] x1_c, y1_c;
  logic signed [DW-1:0] dx1_c, dy1_c;
  logic neg_a_c, neg_b_c, miss_c;
  logic [QB-1:0] qa, qb;
  logic ok_a, ok_b;
  logic signed [QB-1:0] ua, ub;
  logic signed [CMPW-1:0] ua_e, ub_e, tol_e;
  logic hit_c;

  assign {x1_c, y1_c, dx1_c, dy1_c, neg_a_c, neg_b_c, miss_c} = c_side[QB];
  assign qa = c_q[QB][0];
  assign qb = c_q[QB][1];

  // Range check: a negative quotient may reach one step further.
  assign ok_a = !qa[QB-1] || (neg_a_c && (qa[QB-2:0] == '0));
  assign ok_b = !qb[QB-1] || (neg_b_c && (qb[QB-2:0] == '0));
  assign ua   = neg_a_c ? -$signed(qa) : $signed(qa);
  assign ub   = neg_b_c ? -$signed(qb) : $signed(qb);
  assign ua_e  = CMPW'(ua);
  assign ub_e  = CMPW'(ub);
  assign tol_e = $signed(CMPW'(tol_r));
  assign hit_c = !miss_c && ok_a && ok_b &&
                 (ua_e > -tol_e) && (ua_e < ONE_C + tol_e) &&
                 (ub_e > -tol_e) && (ub_e < ONE_C + tol_e);

  // Stage: hit decision.
  logic vf_r, hit_f_r;
  logic signed [QB-1:0] ua_f_r, ub_f_r;
  logic signed [CW-1:0] x1_f_r, y1_f_r;
  logic signed [DW-1:0] dx1_f_r, dy1_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_f_r <= hit_c;
      ua_f_r  <= hit_c ? ua : '0;
      ub_f_r  <= hit_c ? ub : '0;
      x1_f_r  <= x1_c;
      y1_f_r  <= y1_c;
      dx1_f_r <= dx1_c;
      dy1_f_r <= dy1_c;
    end
  end

  // Stage: parameter times the first segment's direction.
  logic vm_r, hit_m_r;
  logic signed [QB-1:0] ua_m_r, ub_m_r;
  logic signed [CW-1:0] x1_m_r, y1_m_r;
  logic signed [MULW-1:0] mx_r, my_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_m_r <= hit_f_r;
      ua_m_r  <= ua_f_r;
      ub_m_r  <= ub_f_r;
      x1_m_r  <= x1_f_r;
      y1_m_r  <= y1_f_r;
      mx_r    <= MULW'(ua_f_r) * MULW'(dx1_f_r);
      my_r    <= MULW'(ua_f_r) * MULW'(dy1_f_r);
    end
  end

  // Output register: point = start + ua * direction.
  logic vo_r, hit_o_r;
  logic signed [QB-1:0] pf_o_r, ps_o_r;
  logic signed [POW-1:0] px_o_r, py_o_r;
  logic signed [MULW-1:0] px_sum, py_sum;

  assign px_sum = MULW'($signed({x1_m_r, {F{1'b0}}})) + mx_r;
  assign py_sum = MULW'($signed({y1_m_r, {F{1'b0}}})) + my_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_o_r <= hit_m_r;
      pf_o_r  <= ua_m_r;
      ps_o_r  <= ub_m_r;
      px_o_r  <= hit_m_r ? px_sum[POW-1:0] : '0;
      py_o_r  <= hit_m_r ? py_sum[POW-1:0] : '0;
    end
  end

  // Beat-valid flags along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vf_r <= c_vld[QB];
      vm_r <= vf_r;
      vo_r <= vm_r;
    end
  end

  assign out_ch.valid        = vo_r;
  assign out_ch.hit          = hit_o_r;
  assign out_ch.param_first  = pf_o_r;
  assign out_ch.param_second = ps_o_r;
  assign out_ch.point_x      = px_o_r;
  assign out_ch.point_y      = py_o_r;

  // A miss carries all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> (out_ch.param_first == '0) &&
      (out_ch.param_second == '0) && (out_ch.point_x == '0) && (out_ch.point_y == '0))
    else $error("miss beat with nonzero payload");

  // A hit never reports a parameter at or below minus the tolerance.
  a_hit_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |->
      ($signed(CMPW'(out_ch.param_first)) > -$signed(CMPW'(tol_r))) &&
      ($signed(CMPW'(out_ch.param_second)) > -$signed(CMPW'(tol_r))))
    else $error("hit parameter outside tolerance band");

  // Input is refused only while a result beat is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output back-pressure");

endmodule

// ----- tb/sv/sic_tb_if.sv -----
`timescale 1ns / 1ps

// Test-side interfaces are provided by the design; this file holds the
// beat records that the testbench keeps for each segment pair and its crossing.
package sic_tb_pkg;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic signed [15:0] x3;
    logic signed [15:0] y3;
    logic signed [15:0] x4;
    logic signed [15:0] y4;
  } seg_pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [18:0] ua;
    logic signed [18:0] ub;
    logic signed [34:0] px;
    logic signed [34:0] py;
  } crossing_t;

endpackage

// ----- tb/sv/segment_intersection_core_tb.sv -----
`timescale 1ns / 1ps

module segment_intersection_core_tb;

  localparam int FRAC = 16;
  localparam int LATENCY = 8 + FRAC + 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [sic_pkg::TOL_W-1:0] cfg_wr_data = '0;

  sic_in_if #(.COORD_BITS(16)) in_ch ();
  sic_out_if #(.COORD_BITS(16), .FRAC_BITS(16)) out_ch ();

  segment_intersection_core #(.COORD_BITS(16), .FRAC_BITS(16)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  logic [15:0] tol_shadow = sic_pkg::TOL_RESET;
  sic_tb_pkg::crossing_t expected_crossings[$];
  int errors = 0;
  int sink_idle_pct = 24;
  int sink_hold = 0;
  int src_idle_pct = 24;

  // Signed quotient num/den scaled by 2^16, truncated toward zero;
  // returns 0 when the magnitude does not fit the parameter width.
  function automatic bit scaled_quot(longint num, longint den, output longint q);
    longint un, ud, mag;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = 0;
    // Magnitudes here stay below 2^35, so scaling fits in 64 bits.
    mag = (un << FRAC) / ud;
    if (mag >= (64'sd1 << 20)) return 0;
    q = neg ? -mag : mag;
    if (q < -(64'sd1 << 18) || q > (64'sd1 << 18) - 1) return 0;
    return 1;
  endfunction

  function automatic sic_tb_pkg::crossing_t predict_crossing(sic_tb_pkg::seg_pair_t s);
    sic_tb_pkg::crossing_t r;
    longint dx1, dy1, dx2, dy2, ox, oy, den, na, nb, ua, ub, tol, one;
    r = '0;
    dx1 = longint'(s.x2) - s.x1;  dy1 = longint'(s.y2) - s.y1;
    dx2 = longint'(s.x4) - s.x3;  dy2 = longint'(s.y4) - s.y3;
    ox = longint'(s.x1) - s.x3;   oy = longint'(s.y1) - s.y3;
    den = dy2 * dx1 - dx2 * dy1;
    na = dx2 * oy - dy2 * ox;
    nb = dx1 * oy - dy1 * ox;
    tol = longint'(tol_shadow);
    one = 64'sd1 << FRAC;
    if (den == 0) return r;
    if (!scaled_quot(na, den, ua)) return r;
    if (!scaled_quot(nb, den, ub)) return r;
    if (!(ua > -tol && ua < one + tol && ub > -tol && ub < one + tol)) return r;
    r.hit = 1'b1;
    r.ua = ua[18:0];
    r.ub = ub[18:0];
    r.px = 35'(longint'(s.x1) * one + ua * dx1);
    r.py = 35'(longint'(s.y1) * one + ua * dy1);
    return r;
  endfunction

  // Offer one segment pair and wait until the beat is taken. Valid stays
  // high afterwards so that the next pair can follow with no gap.
  task automatic send_pair(sic_tb_pkg::seg_pair_t s, bit may_idle = 1);
    while (may_idle && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_end_x, in_ch.seg1_end_y,
     in_ch.seg2_start_x, in_ch.seg2_start_y, in_ch.seg2_end_x, in_ch.seg2_end_y} <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_crossings = {expected_crossings, predict_crossing(s)};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_crossings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_shadow = v;
    @(posedge clk);
  endtask

  function automatic sic_tb_pkg::seg_pair_t mk(int a, int b, int c, int d, int e, int f,
                                               int g, int h);
    sic_tb_pkg::seg_pair_t s;
    s = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
    return s;
  endfunction

  // Pair built to cross near the middle, with random placement.
  function automatic sic_tb_pkg::seg_pair_t crossing_pair(int span);
    int cx, cy, ax, ay, bx, by;
    cx = $urandom_range(2 * span) - span;  cy = $urandom_range(2 * span) - span;
    ax = $urandom_range(2 * span) - span;  ay = $urandom_range(2 * span) - span;
    bx = $urandom_range(2 * span) - span;  by = $urandom_range(2 * span) - span;
    return mk(cx - ax, cy - ay, cx + ax, cy + ay, cx - bx, cy - by, cx + bx, cy + by);
  endfunction

  task automatic test_directed();
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 10, 0, 10, -5, 10, 5));
    send_pair(mk(0, 0, 10, 0, 0, -5, 0, 5));
    send_pair(mk(0, 0, 10, 0, 11, -5, 11, 5));
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_pair(mk(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
    send_pair(mk(0, 0, 1, 0, 0, -32768, 32767, 32767));
    send_pair(mk(0, 0, 1, 1, 0, 32767, 1, -32768));
    send_pair(mk(-1, -1, -1, -1, 5, 5, 6, 7));
    send_pair(mk(0, 0, 65536 / 2 - 1, 3, 0, 1, 1, 0));
    send_pair(mk(0, 0, 3, 0, 1, 0, 2, 1));
  endtask

  task automatic test_tolerance_settings();
    logic [15:0] tols[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd32768};
    foreach (tols[i]) begin
      write_tolerance(tols[i]);
      send_pair(mk(0, 0, 10, 0, 10, -5, 10, 5));
      send_pair(mk(0, 0, 10, 0, 11, -5, 11, 5));
      send_pair(mk(0, 0, 10, 0, 25, -5, 25, 5));
      repeat (60) send_pair(crossing_pair($urandom_range(1) ? 40 : 32767));
    end
    write_tolerance(sic_pkg::TOL_RESET);
  endtask

  task automatic test_random(int n);
    sic_tb_pkg::seg_pair_t s;
    repeat (n) begin
      case ($urandom_range(3))
        0: s = sic_tb_pkg::seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        1: s = crossing_pair(100);
        2: s = crossing_pair(32767 / 2);
        default: begin
          s = crossing_pair(200);
          s.x4 = s.x3 + (s.x2 - s.x1);
          s.y4 = s.y3 + (s.y2 - s.y1);
        end
      endcase
      send_pair(s);
    end
  endtask

  task automatic test_backpressure();
    // Receiver holds off while the sender keeps offering beats.
    sink_hold = 200;
    repeat (80) send_pair(crossing_pair(500), 0);
    // Sender then pauses until all results have come back.
    drain();
    // Stretch with no idling on either side.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(150);
    src_idle_pct = 24;
    sink_idle_pct = 24;
  endtask

  // Receiver ready, with random idling and an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    sic_tb_pkg::crossing_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_crossings.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_crossings.pop_front();
        if (out_ch.hit !== want.hit) begin
          $error("hit expected %0d actual %0d", want.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.param_first !== want.ua) begin
          $error("param_first expected %0d actual %0d", want.ua, out_ch.param_first);
          errors++;
        end
        if (out_ch.param_second !== want.ub) begin
          $error("param_second expected %0d actual %0d", want.ub, out_ch.param_second);
          errors++;
        end
        if (out_ch.point_x !== want.px) begin
          $error("point_x expected %0d actual %0d", want.px, out_ch.point_x);
          errors++;
        end
        if (out_ch.point_y !== want.py) begin
          $error("point_y expected %0d actual %0d", want.py, out_ch.point_y);
          errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_end_x, in_ch.seg1_end_y,
     in_ch.seg2_start_x, in_ch.seg2_start_y, in_ch.seg2_end_x, in_ch.seg2_end_y} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance_settings();
    test_backpressure();
    test_random(850);
    drain();
    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sic_pkg.sv
design/sic_if.sv
design/sic_div_cell.sv
design/segment_intersection_core.sv
tb/sv/sic_tb_if.sv
tb/sv/segment_intersection_core_tb.sv
